// ===== design/lcs_pkg.sv =====
// Shared types, constants and the month table of the local calendar converter.
package lcs_pkg;

  // Number of register stages in one seconds-to-calendar split.
  localparam int unsigned SPLIT_STAGES = 5;

  // Plain calendar constants.
  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned DAYS_PER_QUAD = 365 * 4 + 1;
  localparam int unsigned QUARTER_SECS  = 900;
  localparam int unsigned HOUR_SECS     = 3600;
  localparam int unsigned DAYS_PER_WEEK = 7;
  localparam int unsigned SECS_PER_MIN  = 60;

  // Reciprocals for exact division by constants over the value ranges used.
  // seconds / 86400 is taken as (seconds >> 7) / 675.
  localparam int unsigned DAY_SHIFT  = 35;
  localparam int unsigned DAY_RECIP  = 50903317;
  localparam int unsigned QUAD_SHIFT = 27;
  localparam int unsigned QUAD_RECIP = 91868;
  localparam int unsigned WEEK_SHIFT = 19;
  localparam int unsigned WEEK_RECIP = 74899;
  localparam int unsigned MIN_SHIFT  = 23;
  localparam int unsigned MIN_RECIP  = 139811;
  localparam int unsigned HOUR_SHIFT = 17;
  localparam int unsigned HOUR_RECIP = 2185;

  // Broken-down calendar time.
  typedef struct packed {
    logic [4:0] day;
    logic [3:0] month;
    logic [7:0] year;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] wday;
  } civil_t;

  // Zero-based day of the year on which a month starts.
  function automatic logic [8:0] month_start(input logic [3:0] month, input logic leap);
    logic [8:0] base;
    case (month)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (month > 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

// ===== design/local_calendar_from_seconds.sv =====
// Top level: UTC seconds to local calendar date and time with daylight saving.
//
//   Channel   Handshake        Payload
//   command   start / busy     utc_seconds_i, want_local_i
//   result    done_o strobe    day_of_month_o .. weekday_o, dst_active_o
//   config    cfg_we_i         cfg_idx_i, cfg_wdata_i
//
// One item is taken in every cycle; busy is never raised. Each result passes
// through one input stage, two five-stage calendar splits and one daylight
// saving stage between them. Reset clears the valid bits and sets the zone
// offset and rule to zero. The receiver cannot stall the results, so the
// pipeline never holds.
module local_calendar_from_seconds
  import lcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] utc_seconds_i,
  input  logic        want_local_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [6:0]  cfg_wdata_i,
  output logic        done_o,
  output logic [4:0]  day_of_month_o,
  output logic [3:0]  month_number_o,
  output logic [7:0]  years_since_2000_o,
  output logic [4:0]  hour_of_day_o,
  output logic [5:0]  minute_of_hour_o,
  output logic [5:0]  second_of_minute_o,
  output logic [2:0]  weekday_o,
  output logic        dst_active_o
);

  typedef enum logic {
    REG_ZONE = 1'b0,
    REG_RULE = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    RULE_NONE = 2'd0,
    RULE_SU   = 2'd1,
    RULE_EU   = 2'd2,
    RULE_US   = 2'd3
  } dst_rule_e;

  assign busy = 1'b0;

  // Configuration registers.
  logic signed [6:0] zone_q;
  dst_rule_e         rule_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= '0;
      rule_q <= RULE_NONE;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_ZONE: zone_q <= $signed(cfg_wdata_i);
        REG_RULE: rule_q <= dst_rule_e'(cfg_wdata_i[1:0]);
        default:  ;
      endcase
    end
  end

  // Input stage: add the standard zone offset for local time.
  logic signed [17:0] zone_secs;
  logic               va_q;
  logic [31:0]        ta_q;
  logic               loc_a_q;

  assign zone_secs = 18'(zone_q) * 18'sd900;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    loc_a_q <= want_local_i;
    ta_q    <= want_local_i ? (utc_seconds_i + 32'(zone_secs)) : utc_seconds_i;
  end

  // First split of the standard time; the seconds and flag ride alongside.
  logic        v1;
  civil_t      c1;
  logic [31:0] t_dly_q   [SPLIT_STAGES];
  logic        loc_dly_q [SPLIT_STAGES];

  lcs_split u_split_std (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (va_q),
    .secs_i  (ta_q),
    .valid_o (v1),
    .date_o  (c1)
  );

  always_ff @(posedge clk_i) begin
    t_dly_q[0]   <= ta_q;
    loc_dly_q[0] <= loc_a_q;
    for (int i = 1; i < SPLIT_STAGES; i++) begin
      t_dly_q[i]   <= t_dly_q[i-1];
      loc_dly_q[i] <= loc_dly_q[i-1];
    end
  end

  // Daylight saving decision on the standard local date.
  logic              dst;
  logic [5:0]        next_sun;
  logic [5:0]        to_end;
  logic [5:0]        last_sun;
  logic [5:0]        wrap;
  logic [5:0]        first_sun;
  logic [5:0]        trans;
  logic signed [6:0] th;
  logic signed [6:0] hour_s;

  always_comb begin
    next_sun  = 6'(c1.day) + 6'd7 - 6'(c1.wday);
    to_end    = 6'd31 - next_sun;
    wrap      = next_sun - 6'd1;
    hour_s    = $signed({2'b00, c1.hour});
    dst       = 1'b0;
    last_sun  = next_sun;
    first_sun = 6'd1;
    trans     = 6'd1;
    th        = 7'sd2;

    // Last Sunday of a 31-day month.
    if (next_sun > 6'd31) begin
      last_sun = next_sun - 6'd7;
    end else if (to_end >= 6'd28) begin
      last_sun = next_sun + 6'd28;
    end else if (to_end >= 6'd21) begin
      last_sun = next_sun + 6'd21;
    end else if (to_end >= 6'd14) begin
      last_sun = next_sun + 6'd14;
    end else if (to_end >= 6'd7) begin
      last_sun = next_sun + 6'd7;
    end

    // First Sunday of the month.
    if (wrap >= 6'd35) begin
      first_sun = wrap - 6'd34;
    end else if (wrap >= 6'd28) begin
      first_sun = wrap - 6'd27;
    end else if (wrap >= 6'd21) begin
      first_sun = wrap - 6'd20;
    end else if (wrap >= 6'd14) begin
      first_sun = wrap - 6'd13;
    end else if (wrap >= 6'd7) begin
      first_sun = wrap - 6'd6;
    end else begin
      first_sun = wrap + 6'd1;
    end

    case (rule_q) inside
      RULE_SU, RULE_EU: begin
        // EU switches at 01:00 UTC, so the local hour follows the zone.
        if (rule_q == RULE_EU) begin
          th = 7'sd1 + (zone_q >>> 2);
        end
        if ((c1.month > 4'd3) && (c1.month < 4'd10)) begin
          dst = 1'b1;
        end else if ((c1.month == 4'd3) || (c1.month == 4'd10)) begin
          if (6'(c1.day) < last_sun) begin
            dst = (c1.month == 4'd10);
          end else if (6'(c1.day) > last_sun) begin
            dst = (c1.month == 4'd3);
          end else begin
            dst = (c1.month == 4'd3) ? (hour_s >= th) : (hour_s < th);
          end
        end
      end
      RULE_US: begin
        // Second Sunday of March to first Sunday of November.
        trans = (c1.month == 4'd3) ? (first_sun + 6'd7) : first_sun;
        if ((c1.month > 4'd3) && (c1.month < 4'd11)) begin
          dst = 1'b1;
        end else if ((c1.month == 4'd3) || (c1.month == 4'd11)) begin
          if (6'(c1.day) < trans) begin
            dst = (c1.month == 4'd11);
          end else if (6'(c1.day) > trans) begin
            dst = (c1.month == 4'd3);
          end else begin
            dst = (c1.month == 4'd3) ? (c1.hour >= 5'd2) : (c1.hour < 5'd2);
          end
        end
      end
      default: dst = 1'b0;
    endcase

    dst = dst && loc_dly_q[SPLIT_STAGES-1];
  end

  // Daylight saving stage: add the extra hour where it applies.
  logic        vb_q;
  logic [31:0] tb_q;
  logic        dstb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= v1;
    end
  end

  always_ff @(posedge clk_i) begin
    dstb_q <= dst;
    tb_q   <= dst ? (t_dly_q[SPLIT_STAGES-1] + 32'(HOUR_SECS)) : t_dly_q[SPLIT_STAGES-1];
  end

  // Second split gives the delivered date; the flag rides alongside.
  civil_t c2;
  logic   dst_dly_q [SPLIT_STAGES];

  lcs_split u_split_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vb_q),
    .secs_i  (tb_q),
    .valid_o (done_o),
    .date_o  (c2)
  );

  always_ff @(posedge clk_i) begin
    dst_dly_q[0] <= dstb_q;
    for (int i = 1; i < SPLIT_STAGES; i++) begin
      dst_dly_q[i] <= dst_dly_q[i-1];
    end
  end

  assign day_of_month_o     = c2.day;
  assign month_number_o     = c2.month;
  assign years_since_2000_o = c2.year;
  assign hour_of_day_o      = c2.hour;
  assign minute_of_hour_o   = c2.minute;
  assign second_of_minute_o = c2.second;
  assign weekday_o          = c2.wday;
  assign dst_active_o       = dst_dly_q[SPLIT_STAGES-1];

endmodule

// ===== design/lcs_split.sv =====
// Five-stage pipeline that splits a count of seconds into a calendar date and time.
module lcs_split
  import lcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [31:0] secs_i,
  output logic        valid_o,
  output civil_t      date_o
);

  // Valid bits travel with each item.
  logic [SPLIT_STAGES-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[SPLIT_STAGES-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[SPLIT_STAGES-1];

  // Stage 1: whole days from the seconds count.
  logic [50:0] day_prod;
  logic [15:0] s1_days_d, s1_days_q;
  logic [31:0] s1_secs_q;

  assign day_prod  = 51'(secs_i[31:7]) * 51'(DAY_RECIP);
  assign s1_days_d = day_prod[DAY_SHIFT +: 16];

  always_ff @(posedge clk_i) begin
    s1_days_q <= s1_days_d;
    s1_secs_q <= secs_i;
  end

  // Stage 2: second of the day and four-year blocks.
  logic [31:0] day_secs;
  logic [32:0] quad_prod;
  logic [16:0] s2_tod_q;
  logic [15:0] s2_days_q;
  logic [5:0]  s2_quads_q;

  assign day_secs  = 32'(s1_days_q) * 32'(SECS_PER_DAY);
  assign quad_prod = 33'(s1_days_q) * 33'(QUAD_RECIP);

  always_ff @(posedge clk_i) begin
    s2_tod_q   <= 17'(s1_secs_q - day_secs);
    s2_days_q  <= s1_days_q;
    s2_quads_q <= quad_prod[QUAD_SHIFT +: 6];
  end

  // Stage 3: day within the block, minutes of the day and whole weeks.
  logic [15:0] wk_days;
  logic [34:0] min_prod;
  logic [32:0] wk_prod;
  logic [10:0] s3_rest_q;
  logic [5:0]  s3_quads_q;
  logic [16:0] s3_tod_q;
  logic [10:0] s3_mins_q;
  logic [15:0] s3_wkdays_q;
  logic [12:0] s3_weeks_q;

  assign wk_days  = s2_days_q + 16'(5);
  assign min_prod = 35'(s2_tod_q) * 35'(MIN_RECIP);
  assign wk_prod  = 33'(wk_days) * 33'(WEEK_RECIP);

  always_ff @(posedge clk_i) begin
    s3_rest_q   <= 11'(s2_days_q - 16'(s2_quads_q) * 16'(DAYS_PER_QUAD));
    s3_quads_q  <= s2_quads_q;
    s3_tod_q    <= s2_tod_q;
    s3_mins_q   <= min_prod[MIN_SHIFT +: 11];
    s3_wkdays_q <= wk_days;
    s3_weeks_q  <= wk_prod[WEEK_SHIFT +: 13];
  end

  // Stage 4: year and day of year, seconds, hours and weekday.
  logic [1:0]  extra;
  logic [8:0]  doy;
  logic [22:0] hour_prod;
  logic [15:0] wk_rem;
  logic [7:0]  s4_year_q;
  logic [8:0]  s4_doy_q;
  logic        s4_leap_q;
  logic [5:0]  s4_sec_q;
  logic [10:0] s4_mins_q;
  logic [4:0]  s4_hour_q;
  logic [2:0]  s4_wday_q;

  // The first year of each block is the leap year and has 366 days.
  always_comb begin
    if (s3_rest_q >= 11'd1096) begin
      extra = 2'd3;
      doy   = 9'(s3_rest_q - 11'd1096);
    end else if (s3_rest_q >= 11'd731) begin
      extra = 2'd2;
      doy   = 9'(s3_rest_q - 11'd731);
    end else if (s3_rest_q >= 11'd366) begin
      extra = 2'd1;
      doy   = 9'(s3_rest_q - 11'd366);
    end else begin
      extra = 2'd0;
      doy   = 9'(s3_rest_q);
    end
  end

  assign hour_prod = 23'(s3_mins_q) * 23'(HOUR_RECIP);
  assign wk_rem    = s3_wkdays_q - 16'(s3_weeks_q) * 16'(DAYS_PER_WEEK);

  always_ff @(posedge clk_i) begin
    s4_year_q <= {s3_quads_q, extra};
    s4_doy_q  <= doy;
    s4_leap_q <= (extra == 2'd0);
    s4_sec_q  <= 6'(s3_tod_q - 17'(s3_mins_q) * 17'(SECS_PER_MIN));
    s4_mins_q <= s3_mins_q;
    s4_hour_q <= hour_prod[HOUR_SHIFT +: 5];
    s4_wday_q <= 3'(wk_rem) + 3'd1;
  end

  // Stage 5: month search over the start days, then day of month and minute.
  logic [3:0] month;
  logic [8:0] mstart;

  always_comb begin
    month = 4'd1;
    for (int m = 2; m <= 12; m++) begin
      if (s4_doy_q >= month_start(4'(m), s4_leap_q)) begin
        month = month + 4'd1;
      end
    end
  end

  assign mstart = month_start(month, s4_leap_q);

  always_ff @(posedge clk_i) begin
    date_o.day    <= 5'(s4_doy_q - mstart) + 5'd1;
    date_o.month  <= month;
    date_o.year   <= s4_year_q;
    date_o.hour   <= s4_hour_q;
    date_o.minute <= 6'(s4_mins_q - 11'(s4_hour_q) * 11'(SECS_PER_MIN));
    date_o.second <= s4_sec_q;
    date_o.wday   <= s4_wday_q;
  end

endmodule

// ===== sim/calendar_checker.sv =====
// Rule codes, register indexes and the self-checking monitor of the calendar converter.
package lcs_tb_pkg;

  // Daylight saving rules as held in the rule register.
  typedef enum logic [1:0] {
    RULE_NONE = 2'd0,
    RULE_SU   = 2'd1,
    RULE_EU   = 2'd2,
    RULE_US   = 2'd3
  } dst_rule_e;

  // Register indexes on the configuration port.
  localparam logic REG_ZONE = 1'b0;
  localparam logic REG_RULE = 1'b1;

  // Length of a month; every fourth year from 2000 is a leap year.
  function automatic int unsigned month_days(int unsigned mon, int unsigned yr);
    if (mon == 2) begin
      return (yr % 4 != 0) ? 28 : 29;
    end
    if (mon == 4 || mon == 6 || mon == 9 || mon == 11) begin
      return 30;
    end
    return 31;
  endfunction

endpackage

module calendar_checker
  import lcs_pkg::*;
  import lcs_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [31:0] utc_seconds_i,
  input  logic        want_local_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        done_i,
  input  logic [4:0]  day_of_month_i,
  input  logic [3:0]  month_number_i,
  input  logic [7:0]  years_since_2000_i,
  input  logic [4:0]  hour_of_day_i,
  input  logic [5:0]  minute_of_hour_i,
  input  logic [5:0]  second_of_minute_i,
  input  logic [2:0]  weekday_i,
  input  logic        dst_active_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One predicted result: the calendar fields and the daylight saving flag.
  typedef struct packed {
    civil_t cal;
    logic   dst;
  } calendar_result_t;

  logic signed [6:0] zone_q;
  dst_rule_e         rule_q;
  calendar_result_t  expected_dates[$];
  calendar_result_t  want;
  calendar_result_t  got;

  // Break a count of seconds since 2000 into date, time of day and weekday.
  function automatic civil_t split_seconds(logic [31:0] t);
    int unsigned days, tod, quads, rest, yr, mon, dd, extra, len;
    civil_t c;
    days  = t / SECS_PER_DAY;
    tod   = t % SECS_PER_DAY;
    quads = days / DAYS_PER_QUAD;
    rest  = days % DAYS_PER_QUAD;
    yr    = 4 * quads;
    mon   = 1;
    // Past the first (leap) year of the four-year block.
    if (rest > 365) begin
      extra = (rest - 1) / 365;
      yr    = yr + extra;
      rest  = rest - 1 - 365 * extra;
    end
    dd = rest + 1;
    while (mon < 12) begin
      len = month_days(mon, yr);
      if (dd <= len) break;
      dd  = dd - len;
      mon = mon + 1;
    end
    c.day    = 5'(dd);
    c.month  = 4'(mon);
    c.year   = 8'(yr);
    c.second = 6'(tod % 60);
    c.minute = 6'((tod / 60) % 60);
    c.hour   = 5'(tod / HOUR_SECS);
    c.wday   = 3'(1 + (5 + days) % 7);
    return c;
  endfunction

  // Whether the daylight saving hour applies to a standard local time.
  function automatic logic dst_in_force(civil_t c, dst_rule_e rule, int zone);
    int mon, day, hour, next_sun, last_sun, first_sun, trans, th;
    mon      = c.month;
    day      = c.day;
    hour     = c.hour;
    next_sun = day + 7 - int'(c.wday);
    if (rule == RULE_SU || rule == RULE_EU) begin
      if (mon > 3 && mon < 10) return 1'b1;
      if (mon != 3 && mon != 10) return 1'b0;
      // Both transition months are treated as 31 days long.
      if (next_sun > 31) last_sun = next_sun - 7;
      else last_sun = next_sun + 7 * ((31 - next_sun) / 7);
      if (day < last_sun) return mon == 10;
      if (day > last_sun) return mon == 3;
      // The EU change is at 01:00 UTC, so its local hour follows the zone.
      th = (rule == RULE_EU) ? 1 + (zone >>> 2) : 2;
      return (mon == 3) ? (hour >= th) : (hour < th);
    end
    if (rule == RULE_US) begin
      if (mon > 3 && mon < 11) return 1'b1;
      if (mon != 3 && mon != 11) return 1'b0;
      first_sun = ((next_sun - 1) % 7) + 1;
      trans     = (mon == 3) ? first_sun + 7 : first_sun;
      if (day < trans) return mon == 11;
      if (day > trans) return mon == 3;
      return (mon == 3) ? (hour >= 2) : (hour < 2);
    end
    return 1'b0;
  endfunction

  // Full conversion of one item under the given settings.
  function automatic calendar_result_t convert_item(logic [31:0] secs, logic local_req,
                                                    int zone, dst_rule_e rule);
    logic [31:0]      t;
    calendar_result_t r;
    t     = secs;
    r.dst = 1'b0;
    if (local_req) begin
      t     = t + 32'(zone * 900);
      r.dst = dst_in_force(split_seconds(t), rule, zone);
      if (r.dst) t = t + HOUR_SECS;
    end
    r.cal = split_seconds(t);
    return r;
  endfunction

  // Track the registers, queue predictions and compare each result.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q   = '0;
      rule_q   = RULE_NONE;
      expected_dates.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_ZONE) zone_q = cfg_wdata_i;
        else rule_q = dst_rule_e'(cfg_wdata_i[1:0]);
      end
      if (start_i && !busy_i) begin
        expected_dates.push_back(convert_item(utc_seconds_i, want_local_i, int'(zone_q), rule_q));
      end
      if (done_i) begin
        got.cal.day    = day_of_month_i;
        got.cal.month  = month_number_i;
        got.cal.year   = years_since_2000_i;
        got.cal.hour   = hour_of_day_i;
        got.cal.minute = minute_of_hour_i;
        got.cal.second = second_of_minute_i;
        got.cal.wday   = weekday_i;
        got.dst        = dst_active_i;
        if (expected_dates.size() == 0) begin
          if (errors_o < 10) $display("%0t: result with no item outstanding", $realtime);
          errors_o = errors_o + 1;
        end else begin
          want = expected_dates.pop_front();
          if (got.cal.day !== want.cal.day || got.cal.month !== want.cal.month ||
              got.cal.year !== want.cal.year || got.cal.hour !== want.cal.hour ||
              got.cal.minute !== want.cal.minute || got.cal.second !== want.cal.second ||
              got.cal.wday !== want.cal.wday || got.dst !== want.dst) begin
            if (errors_o < 10) begin
              $display("%0t: expected %0d/%0d/+%0d %0d:%0d:%0d wd %0d dst %0b", $realtime,
                       want.cal.day, want.cal.month, want.cal.year, want.cal.hour,
                       want.cal.minute, want.cal.second, want.cal.wday, want.dst);
              $display("%0t:      got %0d/%0d/+%0d %0d:%0d:%0d wd %0d dst %0b", $realtime,
                       got.cal.day, got.cal.month, got.cal.year, got.cal.hour,
                       got.cal.minute, got.cal.second, got.cal.wday, got.dst);
            end
            errors_o = errors_o + 1;
          end
        end
      end
      pending_o = expected_dates.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// Stimulus and verdict for the local calendar converter, with the checker beside it.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lcs_tb_pkg::*;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        start         = 1'b0;
  logic [31:0] utc_seconds_i = '0;
  logic        want_local_i  = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = REG_ZONE;
  logic [6:0]  cfg_wdata_i   = '0;
  logic        busy;
  logic        done_o;
  logic [4:0]  day_of_month_o;
  logic [3:0]  month_number_o;
  logic [7:0]  years_since_2000_o;
  logic [4:0]  hour_of_day_o;
  logic [5:0]  minute_of_hour_o;
  logic [5:0]  second_of_minute_o;
  logic [2:0]  weekday_o;
  logic        dst_active_o;
  int          failures;
  int          pending;

  int          cur_zone  = 999;
  dst_rule_e   cur_rule  = RULE_NONE;
  logic        idling_on = 1'b1;

  local_calendar_from_seconds uut (
    .clk_i, .rst_ni, .start, .busy, .utc_seconds_i, .want_local_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .done_o, .day_of_month_o, .month_number_o,
    .years_since_2000_o, .hour_of_day_o, .minute_of_hour_o, .second_of_minute_o,
    .weekday_o, .dst_active_o
  );

  calendar_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .utc_seconds_i, .want_local_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .done_i(done_o),
    .day_of_month_i(day_of_month_o), .month_number_i(month_number_o),
    .years_since_2000_i(years_since_2000_o), .hour_of_day_i(hour_of_day_o),
    .minute_of_hour_i(minute_of_hour_o), .second_of_minute_i(second_of_minute_o),
    .weekday_i(weekday_o), .dst_active_i(dst_active_o),
    .errors_o(failures), .pending_o(pending)
  );

  // 4 ns clock.
  always #2 clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  initial begin
    #200_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // UTC seconds of a standard local time in the given zone, wrapped to 32 bits.
  function automatic logic [31:0] local_to_utc(int yr, int mon, int dd, int hr, int mi,
                                               int sec, int zone);
    longint days;
    days = 365 * yr + (yr + 3) / 4 + dd - 1;
    for (int m = 1; m < mon; m++) days = days + month_days(m, yr);
    return 32'(days * 86400 + hr * 3600 + mi * 60 + sec - zone * 900);
  endfunction

  // One register write, held for a single clock.
  task automatic write_reg(logic idx, logic [6:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Stop sending and wait until no result is pending and the pipeline has emptied.
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  // Reprogram both registers once the block is idle.
  task automatic apply_setting(int zone, dst_rule_e rule);
    drain();
    write_reg(REG_ZONE, 7'(zone));
    // Only the low two bits hold the rule; the rest carry noise.
    write_reg(REG_RULE, {5'($urandom), rule});
    cur_zone = zone;
    cur_rule = rule;
  endtask

  // Offer one item, with random gaps before it when idling_on is set, and wait until it is taken.
  task automatic send_item(logic [31:0] secs, logic local_req);
    if (idling_on) begin
      while ($urandom_range(0, 99) < 25) begin
        @(negedge clk_i);
        start         <= 1'b0;
        utc_seconds_i <= $urandom;
      end
    end
    @(negedge clk_i);
    start         <= 1'b1;
    utc_seconds_i <= secs;
    want_local_i  <= local_req;
    do @(posedge clk_i); while (busy);
  endtask

  // A directed item under a given setting.
  task automatic run_case(int zone, dst_rule_e rule, logic [31:0] secs, logic local_req);
    if (zone != cur_zone || rule != cur_rule) apply_setting(zone, rule);
    send_item(secs, local_req);
  endtask

  initial begin
    int        zones [8];
    dst_rule_e rules [8];
    int        zone;
    dst_rule_e rule;
    int        pick, yr, mon, dd, hr, mi, sec, th;

    zones = '{-48, 56, 4, -20, 63, -64, 8, 0};
    rules = '{RULE_EU, RULE_US, RULE_SU, RULE_NONE, RULE_EU, RULE_US, RULE_SU, RULE_EU};

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: range ends, wrap-around, each rule on both sides of its changes.
    run_case(0, RULE_NONE, 32'h0000_0000, 1'b0);
    run_case(0, RULE_NONE, 32'hFFFF_FFFF, 1'b0);
    run_case(0, RULE_NONE, 32'd12345678, 1'b1);
    run_case(-48, RULE_NONE, 32'h0000_0000, 1'b1);
    run_case(56, RULE_NONE, 32'hFFFF_FFFF, 1'b1);
    run_case(-64, RULE_NONE, 32'd100, 1'b1);
    run_case(63, RULE_US, 32'hFFFF_0000, 1'b1);
    run_case(4, RULE_EU, local_to_utc(21, 3, 28, 1, 59, 59, 4), 1'b1);
    run_case(4, RULE_EU, local_to_utc(21, 3, 28, 2, 0, 0, 4), 1'b1);
    run_case(4, RULE_EU, local_to_utc(21, 10, 31, 1, 59, 59, 4), 1'b1);
    run_case(4, RULE_EU, local_to_utc(21, 10, 31, 2, 0, 0, 4), 1'b1);
    // Summer date asked in UTC: the rule must not apply.
    run_case(4, RULE_EU, local_to_utc(21, 7, 1, 12, 0, 0, 4), 1'b0);
    run_case(0, RULE_SU, local_to_utc(24, 3, 31, 1, 59, 59, 0), 1'b1);
    run_case(0, RULE_SU, local_to_utc(24, 3, 31, 2, 0, 0, 0), 1'b1);
    run_case(0, RULE_SU, local_to_utc(24, 10, 27, 1, 59, 59, 0), 1'b1);
    run_case(0, RULE_SU, local_to_utc(24, 10, 27, 2, 0, 0, 0), 1'b1);
    run_case(-20, RULE_US, local_to_utc(21, 3, 14, 1, 59, 59, -20), 1'b1);
    run_case(-20, RULE_US, local_to_utc(21, 3, 14, 2, 0, 0, -20), 1'b1);
    run_case(-20, RULE_US, local_to_utc(21, 11, 7, 1, 59, 59, -20), 1'b1);
    run_case(-20, RULE_US, local_to_utc(21, 11, 7, 2, 0, 0, -20), 1'b1);
    // West of Greenwich the EU change hour is negative locally.
    run_case(-20, RULE_EU, local_to_utc(21, 3, 28, 0, 0, 0, -20), 1'b1);
    run_case(56, RULE_EU, local_to_utc(21, 10, 31, 14, 30, 0, 56), 1'b1);
    // Leap day of 2100 and the last day of a leap year.
    run_case(0, RULE_NONE, local_to_utc(100, 2, 29, 23, 59, 59, 0), 1'b0);
    run_case(0, RULE_NONE, local_to_utc(0, 12, 31, 12, 0, 0, 0), 1'b0);

    // Random phases, each under its own setting; two phases run without gaps.
    for (int p = 0; p < 8; p++) begin
      zone = (p == 7) ? int'($urandom_range(0, 127)) - 64 : zones[p];
      rule = (p == 7) ? dst_rule_e'($urandom_range(0, 3)) : rules[p];
      apply_setting(zone, rule);
      idling_on = !(p == 2 || p == 3);
      for (int n = 0; n < 78; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          // Local times close to a daylight saving change.
          yr = $urandom_range(0, 135);
          case ($urandom_range(0, 4))
            0, 1:    mon = 3;
            2:       mon = 10;
            3:       mon = 11;
            default: mon = $urandom_range(1, 12);
          endcase
          if (mon == 11) dd = $urandom_range(1, 7);
          else if (mon == 3 && rule == RULE_US) dd = $urandom_range(8, 14);
          else if (mon == 3 || mon == 10) dd = $urandom_range(25, 31);
          else dd = $urandom_range(1, month_days(mon, yr));
          th = (rule == RULE_EU) ? 1 + (zone >>> 2) : 2;
          case ($urandom_range(0, 3))
            0:       hr = th - 1;
            1:       hr = th;
            2:       hr = $urandom_range(0, 23);
            default: hr = $urandom_range(0, 4);
          endcase
          if (hr < 0) hr = 0;
          if (hr > 23) hr = 23;
          case ($urandom_range(0, 2))
            0:       begin mi = 59; sec = 59; end
            1:       begin mi = 0; sec = 0; end
            default: begin mi = $urandom_range(0, 59); sec = $urandom_range(0, 59); end
          endcase
          send_item(local_to_utc(yr, mon, dd, hr, mi, sec, zone), 1'b1);
        end else if (pick < 90) begin
          send_item($urandom, 1'($urandom_range(0, 1)));
        end else begin
          // Near either end of the counter, where offsets wrap.
          case ($urandom_range(0, 3))
            0:       send_item(32'h0000_0000, 1'($urandom_range(0, 1)));
            1:       send_item(32'hFFFF_FFFF, 1'($urandom_range(0, 1)));
            2:       send_item(32'($urandom_range(0, 200000)), 1'($urandom_range(0, 1)));
            default: send_item(32'hFFFF_FFFF - 32'($urandom_range(0, 200000)),
                               1'($urandom_range(0, 1)));
          endcase
        end
      end
    end

    drain();
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
